### hdl/ins_sort_pkg.sv
// Package with the shared constants, types and control codes of the insertion sorter.
`default_nettype none

package ins_sort_pkg;

   // Capacity of the sorted store, in elements.
   localparam int DEPTH   = 64;
   // Width of the element count, wide enough to hold DEPTH itself.
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic signed [31:0] value;
      logic               final_item;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               end_of_set;
      logic               overflowed;
   } rsp_type;

   // Per-cycle command shared by every cell of the chain.
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

endpackage : ins_sort_pkg

`default_nettype wire

### hdl/ins_sort_cell.sv
// One cell of the insertion chain: holds one element and trades it with its neighbors.
`default_nettype none

module ins_sort_cell
   import ins_sort_pkg::*;
(
   input  wire logic               clock,
   input  wire cell_ctrl_type      ctrl,
   input  wire logic signed [31:0] new_value,
   input  wire logic               occupied,
   input  wire logic               left_greater,
   input  wire logic signed [31:0] left_value,
   input  wire logic signed [31:0] right_value,
   output logic signed [31:0]      value,
   output logic                    greater
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   // An empty cell counts as greater, so the new element lands on the first free place.
   // Strict compare keeps equal elements in arrival order.
   assign greater = !occupied || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (greater) begin
            value_in = left_greater ? left_value : new_value;
         end
      end else if (ctrl.drain) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule : ins_sort_cell

`default_nettype wire

### hdl/insertion_sorter_top.sv
// Top level of the insertion sorter: a chain of compare-and-shift cells with a drain sequencer.
// Timing: a word is inserted into the chain at the clock edge that accepts it; once the final word
// of a set is accepted the chain drains, and each sorted word leaves through an output register.
// Throughput: one input word per cycle while filling; a finished set then drains through the chain,
// one sorted word per cycle unless the receiver stalls, and the input is stalled until it is out.
// Reset: synchronous, active high; it empties the store and clears the count, the drop flag
// and the output register's valid. Element storage itself is not cleared.
`default_nettype none

module insertion_sorter_top
   import ins_sort_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 drop_ff, drop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;

   logic                 req_accept;
   logic                 full;
   logic                 drain_shift;
   logic                 last_word;
   cell_ctrl_type        ctrl;

   logic signed [31:0]   cell_value [DEPTH];
   logic                 cell_greater [DEPTH];

   // The input is held off only while a finished set is being drained out of the chain.
   assign req_stall  = (state_ff == ST_DRAIN);
   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == COUNT_W'(DEPTH));

   // The output register takes a new word when it is empty or its word is being taken.
   assign drain_shift = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign last_word   = (count_ff == COUNT_W'(1));

   // A word that arrives at a full store is dropped and only marks the set as overflowed.
   assign ctrl = '{insert: req_accept && !full, drain: drain_shift};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_accept) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
               if (req_data.final_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // Each shift moves the lowest element out and every other one down one cell.
            if (drain_shift) begin
               count_in = count_ff - COUNT_W'(1);
               if (last_word) begin
                  drop_in  = 1'b0;
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   // Output register: it parts the chain from the result channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (drain_shift) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_shift) begin
         rsp_data_ff.sorted_value <= cell_value[0];
         rsp_data_ff.end_of_set   <= last_word;
         rsp_data_ff.overflowed   <= drop_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The chain. Cell zero holds the smallest element. On an insert every cell compares its
   // element with the new one at once; cells holding a greater element take the element of
   // their lower neighbor, and the lowest such cell takes the new element. On a drain every
   // cell takes the element of its upper neighbor.
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic               occupied;
      logic               left_greater;
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;

      assign occupied = (COUNT_W'(gi) < count_ff);

      if (gi == 0) begin : g_first
         assign left_greater = 1'b0;
         assign left_value   = req_data.value;
      end else begin : g_inner
         assign left_greater = cell_greater[gi-1];
         assign left_value   = cell_value[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign right_value = cell_value[gi];
      end else begin : g_upper
         assign right_value = cell_value[gi+1];
      end

      ins_sort_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .new_value    (req_data.value),
         .occupied     (occupied),
         .left_greater (left_greater),
         .left_value   (left_value),
         .right_value  (right_value),
         .value        (cell_value[gi]),
         .greater      (cell_greater[gi])
      );
   end

endmodule : insertion_sorter_top

`default_nettype wire

### tb/sv/sort_result_checker.sv
// Checker that predicts the sorted output of the insertion sorter and compares every result word.
`timescale 1ns / 100ps

module sort_result_checker
   import ins_sort_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_stall,
   input  req_type   req_data,
   input  wire logic rsp_valid,
   input  wire logic rsp_stall,
   input  rsp_type   rsp_data,
   output int        error_count,
   output int        pending_words,
   output int        checked_words,
   output int        overflow_sets
);

   typedef logic signed [31:0] element_type;

   element_type held_values[$];
   logic        drop_seen;
   rsp_type     expected_words[$];

   initial begin
      error_count   = 0;
      pending_words = 0;
      checked_words = 0;
      overflow_sets = 0;
      drop_seen     = 1'b0;
   end

   // Insert into the ascending store; an equal value lands above the ones already held.
   task automatic sort_in_word(input req_type w);
      int      pos;
      rsp_type r;
      if (held_values.size() < DEPTH) begin
         pos = held_values.size();
         while (pos > 0 && held_values[pos-1] > w.value) pos--;
         held_values.insert(pos, w.value);
      end else begin
         drop_seen = 1'b1;
      end
      if (w.final_item) begin
         for (int i = 0; i < held_values.size(); i++) begin
            r.sorted_value = held_values[i];
            r.end_of_set   = (i == held_values.size() - 1);
            r.overflowed   = drop_seen;
            expected_words.push_back(r);
         end
         held_values.delete();
         drop_seen = 1'b0;
      end
   endtask

   task automatic compare_word(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected sorted word, got value %0d end %0b overflow %0b",
                  $time, got.sorted_value, got.end_of_set, got.overflowed);
         error_count++;
      end else begin
         want = expected_words.pop_front();
         checked_words++;
         if (got.end_of_set && got.overflowed) overflow_sets++;
         if (got.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value mismatch, expected %0d, actual %0d",
                     $time, want.sorted_value, got.sorted_value);
            error_count++;
         end
         if (got.end_of_set !== want.end_of_set) begin
            $display("%0t: end_of_set mismatch, expected %0b, actual %0b",
                     $time, want.end_of_set, got.end_of_set);
            error_count++;
         end
         if (got.overflowed !== want.overflowed) begin
            $display("%0t: overflowed mismatch, expected %0b, actual %0b",
                     $time, want.overflowed, got.overflowed);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_values.delete();
         expected_words.delete();
         drop_seen = 1'b0;
      end else begin
         if (req_valid && !req_stall) sort_in_word(req_data);
         if (rsp_valid && !rsp_stall) compare_word(rsp_data);
      end
      pending_words = expected_words.size();
   end

endmodule : sort_result_checker

### tb/sv/insertion_sorter_top_test.sv
// Top of the insertion sorter testbench: clock, reset, word stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module insertion_sorter_top_test;
   import ins_sort_pkg::*;

   // Rough number of input words; the last set is always finished, so a few more may go in.
   localparam int ITEM_TARGET   = 270;
   // Upper bound on the run length, many times what the slowest correct run takes.
   localparam int CYCLE_LIMIT   = 200000;
   // Length of the one long receiver hold-off that backs the chain up into its input.
   localparam int HOLD_CYCLES   = 300;
   // Quiet cycles after the last expected word, to catch anything extra from the block.
   localparam int SETTLE_CYCLES = 20;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int error_count;
   int pending_words;
   int checked_words;
   int overflow_sets;

   int sender_idle_pct;
   int receiver_stall_pct;
   int words_sent;
   int sets_sent;
   int cycle_count;
   int hold_left;
   bit long_hold_done;

   insertion_sorter_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sort_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_words (pending_words),
      .checked_words (checked_words),
      .overflow_sets (overflow_sets)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a run that hangs, for example on a block that never drains, ends here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver side. Stalls are drawn fresh at each falling edge from the current phase's
   // percentage. The first time a good backlog of sorted words is waiting, the receiver
   // holds off for a long stretch, so the drain stops and the block has to stall its input
   // while the sender keeps offering words.
   initial begin
      rsp_stall      = 1'b0;
      hold_left      = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && !reset && pending_words >= 20) begin
            long_hold_done = 1'b1;
            hold_left      = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // The idling phase follows progress through the stimulus: first none at all, then a
   // bursty sender, then a slow receiver, then both at a lighter rate.
   task automatic pick_phase();
      case (words_sent * 4 / ITEM_TARGET)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 65;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 65;
         end
         default: begin
            sender_idle_pct    = 35;
            receiver_stall_pct = 35;
         end
      endcase
   endtask

   // Offer one word from a falling edge and return at the falling edge after it is taken.
   // Valid is only lowered when an idle gap is drawn, so back-to-back words keep it high.
   task automatic send_word(input logic signed [31:0] v, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data.value      <= v;
      req_data.final_item <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (last) sets_sent++;
      @(negedge clock);
   endtask

   // Values lean toward the extremes and a narrow band around zero, so that ties and the
   // signed ordering get exercised; the rest are full-width random words.
   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: begin
            case ($urandom_range(3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               2:       return 32'sh0000_0000;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(7)) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(input int len);
      pick_phase();
      for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      words_sent         = 0;
      sets_sent          = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets. The first mixes both extremes, zero, minus one and repeated values,
      // including a repeat of the most negative and most positive word.
      pick_phase();
      send_word(32'sd0, 1'b0);
      send_word(32'sd1, 1'b0);
      send_word(-32'sd1, 1'b0);
      send_word(32'sh7fff_ffff, 1'b0);
      send_word(32'sh8000_0000, 1'b0);
      send_word(32'sd5, 1'b0);
      send_word(32'sd5, 1'b0);
      send_word(-32'sd5, 1'b0);
      send_word(32'sh8000_0000, 1'b0);
      send_word(32'sh7fff_ffff, 1'b1);
      // A set of one: the final word is its only element.
      send_word(32'sh5555_5555, 1'b1);
      // Descending input forces every held element to shift on each insertion.
      send_word(32'sd4, 1'b0);
      send_word(32'sd3, 1'b0);
      send_word(32'sd2, 1'b0);
      send_word(32'sd1, 1'b1);
      // Already ascending input, negative values only.
      send_word(-32'sd3, 1'b0);
      send_word(-32'sd2, 1'b0);
      send_word(-32'sd1, 1'b1);
      // Alternating bit patterns, one negative and one positive.
      send_word(32'shaaaa_aaaa, 1'b0);
      send_word(32'sh5555_5555, 1'b1);

      // A set that exactly fills the store, then one that overflows it so that the final
      // word itself is dropped while the full store is still emitted.
      send_set(DEPTH);
      send_set(DEPTH + 3);

      // Random sets: mostly short, now and then one just past capacity.
      while (words_sent < ITEM_TARGET) begin
         if ($urandom_range(14) == 0) send_set(DEPTH + 1 + $urandom_range(2));
         else send_set(1 + $urandom_range(15));
      end
      req_valid <= 1'b0;

      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d words in %0d sets; checked %0d sorted words.",
               words_sent, sets_sent, checked_words);
      $display("Sets with dropped elements: %0d; long receiver hold-off applied: %0b.",
               overflow_sets, long_hold_done);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule : insertion_sorter_top_test
